@@ sv/sha1he_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Shared constants, state codes and the control bundle between the sequencer
// and the compression datapath.
// ----------------------------------------------------------------------------
package sha1he_pkg;

   // Width of the running message length counter in bits (32 to 64).
   localparam int LENGTH_BITS = 64;

   localparam int WORD_BITS    = 32;
   localparam int NUM_HASH     = 5;
   localparam int NUM_ROUNDS   = 80;
   localparam int WINDOW_DEPTH = 16;

   localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

   localparam logic [31:0] HASH_INIT [NUM_HASH] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // Byte position at which the length field begins.
   localparam logic [5:0] LEN_START_POS = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [6:0] LAST_ROUND    = 7'(NUM_ROUNDS - 1);
   localparam logic [2:0] LAST_WORD_IDX = 3'(NUM_HASH - 1);

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_CMP_LOAD,
      ST_CMP_ROUND,
      ST_CMP_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;   // copy hash words into the working variables
      logic       step;   // run one round
      logic       add;    // fold the working variables into the hash words
      logic       init;   // restore the initial hash words
      logic [6:0] round;  // current round number
   } ctl_type;

endpackage

@@ sv/sha1he_ifs.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine channel interfaces
// Request channel (message bytes and finish commands) and response channel
// (digest words), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sha1he_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha1he_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

@@ sv/sha1he_block_ram.sv @@
// ----------------------------------------------------------------------------
// SHA-1 block store
// Sixteen 32-bit words with a byte-lane write port and a registered read
// port. Byte lane 0 is the most significant byte of a word.
// ----------------------------------------------------------------------------
module sha1he_block_ram
   import sha1he_pkg::*;
(
   input  logic        clock,
   input  logic        wr_en,
   input  logic [3:0]  wr_addr,
   input  logic [1:0]  wr_lane,
   input  logic [7:0]  wr_data,
   input  logic [3:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem_ff [WINDOW_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr][{~wr_lane, 3'b000} +: 8] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sha1he_compress.sv @@
// ----------------------------------------------------------------------------
// SHA-1 compression datapath
// Holds the hash words, the working variables and the rolling 16-word message
// schedule, and runs one round per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
module sha1he_compress
   import sha1he_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   input  logic [31:0] rd_data,
   input  logic [2:0]  hash_sel,
   output logic [31:0] hash_word
);

   logic [31:0] hash_ff   [NUM_HASH];
   logic [31:0] work_ff   [NUM_HASH];
   logic [31:0] window_ff [WINDOW_DEPTH];

   logic [31:0] mix;
   logic [31:0] w;
   logic [31:0] f;
   logic [31:0] k;
   logic [31:0] t;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   always_comb begin
      // The window holds W[r-16] at the bottom and W[r-1] at the top.
      mix = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
      w   = (ctl.round < 7'd16) ? rd_data : rotl(mix, 1);

      if (ctl.round < 7'd20) begin
         f = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k = K_ROUND_0;
      end else if (ctl.round < 7'd40) begin
         f = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k = K_ROUND_1;
      end else if (ctl.round < 7'd60) begin
         f = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
           | (work_ff[2] & work_ff[3]);
         k = K_ROUND_2;
      end else begin
         f = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k = K_ROUND_3;
      end

      t = f + k + rotl(work_ff[0], 5) + work_ff[4] + w;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            hash_ff[i] <= HASH_INIT[i];
         end
      end else if (ctl.add) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            hash_ff[i] <= hash_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         for (int i = 0; i < NUM_HASH; i++) begin
            work_ff[i] <= hash_ff[i];
         end
      end else if (ctl.step) begin
         work_ff[0] <= t;
         work_ff[1] <= work_ff[0];
         work_ff[2] <= rotl(work_ff[1], 30);
         work_ff[3] <= work_ff[2];
         work_ff[4] <= work_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
         window_ff[WINDOW_DEPTH - 1] <= w;
      end
   end

   assign hash_word = hash_ff[hash_sel];

endmodule

@@ sv/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Absorb item: the byte goes into the block store; a full 64-byte block is
// compressed (load, 80 rounds, hash update), one round per cycle through the
// shared round unit. Finish item: pad bytes one per cycle up to the length
// field, a step with no write before the length field, one or two
// compressions, then five digest words, one per cycle when the sink is ready.
// Synchronous reset restores the initial hash words and clears the length.
// ----------------------------------------------------------------------------
module sha1_hash_engine
   import sha1he_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sha1he_req_if.sink          req_bus,
   sha1he_rsp_if.source        rsp_bus
);

   state_type              state_ff, state_in;
   state_type              ret_ff, ret_in;
   logic [5:0]             pos_ff, pos_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [6:0]             round_ff, round_in;
   logic [2:0]             idx_ff, idx_in;

   logic        wr_en;
   logic [7:0]  wr_data;
   logic [3:0]  rd_addr;
   logic [31:0] rd_data;
   logic [31:0] hash_word;
   logic [63:0] len_ext;
   ctl_type     ctl;

   assign len_ext = 64'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      wr_data   = 8'h00;
      rd_addr   = 4'(round_ff[3:0] + 4'd1);
      ctl       = '0;
      ctl.round = round_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               wr_en  = 1'b1;
               pos_in = 6'(pos_ff + 6'd1);
               if (req_bus.opcode == OP_FINISH) begin
                  wr_data  = PAD_MARK_BYTE;
                  len_in   = count_ff;
                  ret_in   = ST_PAD_ZERO;
                  state_in = (pos_ff == LAST_POS) ? ST_CMP_LOAD : ST_PAD_ZERO;
               end else begin
                  wr_data  = req_bus.data_byte;
                  count_in = count_ff + LENGTH_BITS'(8);
                  ret_in   = ST_IDLE;
                  state_in = (pos_ff == LAST_POS) ? ST_CMP_LOAD : ST_IDLE;
               end
            end
         end

         ST_PAD_ZERO: begin
            if (pos_ff == LEN_START_POS) begin
               state_in = ST_PAD_LEN;
            end else begin
               wr_en  = 1'b1;
               pos_in = 6'(pos_ff + 6'd1);
               if (pos_ff == LAST_POS) begin
                  ret_in   = ST_PAD_ZERO;
                  state_in = ST_CMP_LOAD;
               end
            end
         end

         ST_PAD_LEN: begin
            // The length goes out most significant byte first.
            wr_en   = 1'b1;
            wr_data = len_ext[{~pos_ff[2:0], 3'b000} +: 8];
            pos_in  = 6'(pos_ff + 6'd1);
            if (pos_ff == LAST_POS) begin
               ret_in   = ST_EMIT;
               state_in = ST_CMP_LOAD;
            end
         end

         ST_CMP_LOAD: begin
            rd_addr  = 4'd0;
            ctl.load = 1'b1;
            round_in = '0;
            state_in = ST_CMP_ROUND;
         end

         ST_CMP_ROUND: begin
            ctl.step = 1'b1;
            if (round_ff == LAST_ROUND) begin
               round_in = '0;
               state_in = ST_CMP_ADD;
            end else begin
               round_in = 7'(round_ff + 7'd1);
            end
         end

         ST_CMP_ADD: begin
            ctl.add  = 1'b1;
            state_in = ret_ff;
         end

         ST_EMIT: begin
            if (rsp_bus.ready) begin
               if (idx_ff == LAST_WORD_IDX) begin
                  ctl.init = 1'b1;
                  idx_in   = '0;
                  pos_in   = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = 3'(idx_ff + 3'd1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   sha1he_block_ram u_block_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[5:2]),
      .wr_lane (pos_ff[1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sha1he_compress u_compress (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_data   (rd_data),
      .hash_sel  (idx_ff),
      .hash_word (hash_word)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = (state_ff == ST_EMIT);
   assign rsp_bus.digest_word = hash_word;
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == LAST_WORD_IDX);

endmodule

@@ bench/sha1_hash_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Streams messages one byte item at a time into the engine. Each finish is
// predicted by a local SHA-1 computation, and every digest word that comes
// back is compared field by field against the oldest predicted word. The
// stimulus covers short directed messages, random messages around the block
// boundaries, random idling on both channels and a long response stall.
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb
   import sha1he_pkg::*;
();

   localparam int          CYCLE_LIMIT     = 400000;
   localparam int          RSP_HOLD_CYCLES = 600;
   localparam int          SETTLE_CYCLES   = 300;
   localparam logic [63:0] COUNT_MASK      =
      (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic clock;
   logic reset;

   sha1he_req_if req_ch ();
   sha1he_rsp_if rsp_ch ();

   sha1_hash_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Running SHA-1 state of the message currently being streamed in.
   logic [31:0] hash_acc [NUM_HASH];
   logic [7:0]  block_bytes [64];
   logic [63:0] msg_bit_len;
   logic [5:0]  fill_pos;

   digest_word_type expected_words [$];

   int error_count    = 0;
   int items_sent     = 0;
   int bytes_hashed   = 0;
   int digests_sent   = 0;
   int words_checked  = 0;
   int req_idle_pct   = 20;
   int rsp_idle_pct   = 60;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d digest words outstanding.",
               cycle_count, expected_words.size());
      $display("** sha1_hash_engine: FAILED **");
      $finish;
   end

   function automatic logic [31:0] rotl(input logic [31:0] v, input int k);
      return (v << k) | (v >> (32 - k));
   endfunction

   function automatic void restart_digest();
      int i;
      for (i = 0; i < NUM_HASH; i++) hash_acc[i] = HASH_INIT[i];
      msg_bit_len = '0;
      fill_pos    = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int          i;
      for (i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      a = hash_acc[0];
      b = hash_acc[1];
      c = hash_acc[2];
      d = hash_acc[3];
      e = hash_acc[4];
      for (i = 0; i < NUM_ROUNDS; i++) begin
         // The schedule is kept as a 16-word window that is overwritten in place.
         if (i >= 16)
            w[i%16] = rotl(w[(i-3)%16] ^ w[(i-8)%16] ^ w[(i-14)%16] ^ w[i%16], 1);
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_ROUND_0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_ROUND_1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_ROUND_2;
         end else begin
            f = b ^ c ^ d;
            k = K_ROUND_3;
         end
         t = rotl(a, 5) + f + e + k + w[i%16];
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_acc[0] += a;
      hash_acc[1] += b;
      hash_acc[2] += c;
      hash_acc[3] += d;
      hash_acc[4] += e;
   endfunction

   function automatic void load_byte(input logic [7:0] value);
      block_bytes[fill_pos] = value;
      fill_pos++;
      if (fill_pos == 6'd0) sha1_compress();
   endfunction

   function automatic void hash_item(input logic op, input logic [7:0] value);
      logic [63:0]     len;
      digest_word_type dw;
      int              k;
      if (op == OP_ABSORB) begin
         load_byte(value);
         msg_bit_len  = (msg_bit_len + 64'd8) & COUNT_MASK;
         bytes_hashed++;
      end else begin
         len = msg_bit_len & COUNT_MASK;
         load_byte(PAD_MARK_BYTE);
         while (fill_pos != LEN_START_POS) load_byte(8'h00);
         for (k = 0; k < 8; k++) load_byte(len[63 - 8*k -: 8]);
         for (k = 0; k < NUM_HASH; k++) begin
            dw.word  = hash_acc[k];
            dw.index = 3'(k);
            dw.last  = (3'(k) == LAST_WORD_IDX);
            expected_words.push_back(dw);
         end
         digests_sent++;
         restart_digest();
      end
   endfunction

   // Returns at the edge where the item was taken, with valid still high.
   task automatic drive_item(input logic op, input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.data_byte <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      hash_item(op, value);
      items_sent++;
   endtask

   task automatic end_burst();
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int n_bytes, input logic [7:0] finish_byte);
      int i;
      for (i = 0; i < n_bytes; i++) drive_item(OP_ABSORB, 8'($urandom_range(255)));
      drive_item(OP_FINISH, finish_byte);
   endtask

   function automatic int pick_length();
      int boundary_lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int sel;
      sel = $urandom_range(99);
      if (sel < 55) return $urandom_range(12);
      if (sel < 80) return $urandom_range(70, 50);
      if (sel < 92) return boundary_lens[$urandom_range(7)];
      return $urandom_range(135, 100);
   endfunction

   // Empty message, a data byte that must be ignored, and two finishes in a row.
   task automatic test_empty_message();
      drive_item(OP_FINISH, 8'hFF);
      drive_item(OP_FINISH, 8'h00);
      end_burst();
      wait_drain();
   endtask

   task automatic test_short_vectors();
      drive_item(OP_ABSORB, 8'h61);
      drive_item(OP_ABSORB, 8'h62);
      drive_item(OP_ABSORB, 8'h63);
      drive_item(OP_FINISH, 8'h5A);
      drive_item(OP_ABSORB, 8'h00);
      drive_item(OP_ABSORB, 8'hFF);
      drive_item(OP_ABSORB, 8'h80);
      drive_item(OP_ABSORB, 8'h7F);
      drive_item(OP_ABSORB, 8'hAA);
      drive_item(OP_ABSORB, 8'h55);
      drive_item(OP_FINISH, 8'hA5);
      end_burst();
      wait_drain();
   endtask

   task automatic test_random_messages(input int req_pct, input int rsp_pct,
                                       input int item_budget);
      int first_item;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      first_item   = items_sent;
      while (items_sent - first_item < item_budget)
         send_message(pick_length(), 8'($urandom_range(255)));
      end_burst();
      wait_drain();
   endtask

   // The response side stalls for a long stretch while bytes keep coming, so
   // the engine has to hold its digest and push back on the request side.
   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests++;
      send_message(9, 8'($urandom_range(255)));
      send_message(30, 8'($urandom_range(255)));
      send_message(0, 8'($urandom_range(255)));
      end_burst();
      wait_drain();
   endtask

   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_left   <= RSP_HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
         end else begin
            exp_w = expected_words.pop_front();
            words_checked++;
            if (rsp_ch.digest_word !== exp_w.word) begin
               error_count++;
               $display("%0t: digest_word expected %h actual %h", $time,
                        exp_w.word, rsp_ch.digest_word);
            end
            if (rsp_ch.word_index !== exp_w.index) begin
               error_count++;
               $display("%0t: word_index expected %0d actual %0d", $time,
                        exp_w.index, rsp_ch.word_index);
            end
            if (rsp_ch.last_word !== exp_w.last) begin
               error_count++;
               $display("%0t: last_word expected %b actual %b", $time,
                        exp_w.last, rsp_ch.last_word);
            end
         end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_idle_pct);
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = OP_ABSORB;
      req_ch.data_byte = 8'h00;
      restart_digest();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_short_vectors();
      test_random_messages(20, 60, 90);
      test_random_messages(60, 20, 90);
      test_random_messages(0, 0, 90);
      test_output_backpressure();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items: %0d message bytes in %0d messages.",
               items_sent, bytes_hashed, digests_sent);
      $display("Checked %0d digest words; %0d mismatches, %0d words outstanding.",
               words_checked, error_count, expected_words.size());
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("** sha1_hash_engine: PASSED **");
      end else begin
         $display("** sha1_hash_engine: FAILED **");
      end
      $finish;
   end

endmodule
